### rtl/bmda_pkg.sv
// shared types, sizes and constants of the box mean depth accumulator
// no dependencies; used by every file of the block
`timescale 1ns / 1ps

package bmda_pkg;

    localparam int MAX_BOXES  = 16;
    localparam int MAX_DIM    = 4096;
    localparam int DEPTH_BITS = 16;

    localparam int EDGE_W     = 12;
    localparam int SLOT_W     = 4;
    localparam int MARGIN_W   = 8;
    localparam int CFG_DIM_W  = 13;
    localparam int USED_CFG_W = 5;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = POS_W + 1;
    localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int USE_W  = $clog2(MAX_BOXES + 1);
    localparam int SUM_W  = DEPTH_BITS + 2 * POS_W;
    localparam int CNT_W  = 2 * POS_W + 1;
    localparam int CMP_W  = ((POS_W > EDGE_W) ? POS_W : EDGE_W) + 1;
    localparam int SEL_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W);
    localparam int STEP_W = $clog2(DEPTH_BITS);

    localparam logic [CNT_W-1:0] COUNT_START = CNT_W'(1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOXES_IN_USE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN  = 2'd3;

    localparam logic [CFG_DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [USED_CFG_W-1:0] RST_BOXES_IN_USE = 5'd0;
    localparam logic [MARGIN_W-1:0]   RST_EDGE_MARGIN  = 8'd5;

    // input action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // one request travelling down the row of cells
    typedef struct packed {
        logic                  valid;
        logic                  pix;
        logic [SLOT_W-1:0]     slot;
        logic [EDGE_W-1:0]     left;
        logic [EDGE_W-1:0]     top;
        logic [EDGE_W-1:0]     right;
        logic [EDGE_W-1:0]     bottom;
        logic [DEPTH_BITS-1:0] depth;
        logic [POS_W-1:0]      col;
        logic [POS_W-1:0]      row;
        logic                  first;
        logic                  last;
    } bmda_token_t;

    // frame dimension as the raster counter uses it: zero acts as one,
    // anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0)
            return DIM_W'(1);
        if (x > 32'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        return DIM_W'(x);
    endfunction

endpackage

### rtl/bmda_in_if.sv
// request channel into the box mean depth accumulator
// depends on bmda_pkg
`timescale 1ns / 1ps

interface bmda_in_if
    import bmda_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [SLOT_W-1:0]     box_slot;
    logic [EDGE_W-1:0]     left_edge;
    logic [EDGE_W-1:0]     top_edge;
    logic [EDGE_W-1:0]     right_edge;
    logic [EDGE_W-1:0]     bottom_edge;
    logic [DEPTH_BITS-1:0] depth_sample;

    modport source (
        output valid, action, box_slot, left_edge, top_edge, right_edge,
               bottom_edge, depth_sample,
        input  ready
    );

    modport sink (
        input  valid, action, box_slot, left_edge, top_edge, right_edge,
               bottom_edge, depth_sample,
        output ready
    );
endinterface

### rtl/bmda_out_if.sv
// result channel out of the box mean depth accumulator
// depends on bmda_pkg
`timescale 1ns / 1ps

interface bmda_out_if
    import bmda_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [SLOT_W-1:0]     box_number;
    logic [DEPTH_BITS-1:0] mean_depth;
    logic                  last_box;

    modport source (
        output valid, box_number, mean_depth, last_box,
        input  ready
    );

    modport sink (
        input  valid, box_number, mean_depth, last_box,
        output ready
    );
endinterface

### rtl/bmda_cell.sv
// one box cell: bounds, running sum and hit count, passes requests on
// depends on bmda_pkg
`timescale 1ns / 1ps

module bmda_cell
    import bmda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IDX_W-1:0]      cell_idx,
    input  logic [MARGIN_W-1:0]   margin,
    input  bmda_token_t           tok_in,
    output bmda_token_t           tok_out,
    input  logic                  shift_en,
    input  logic [SUM_W-1:0]      sum_in,
    input  logic [CNT_W-1:0]      cnt_in,
    output logic [SUM_W-1:0]      sum_out,
    output logic [CNT_W-1:0]      cnt_out
);

    logic [EDGE_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next, sum_base;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_base;
    logic              tok_valid_reg;
    bmda_token_t       tok_reg;
    logic              slot_hit, pix_hit;
    logic [CMP_W-1:0]  c_ext, r_ext, m_ext;

    assign slot_hit = (SEL_W'(tok_in.slot) == SEL_W'(cell_idx));

    assign c_ext = CMP_W'(tok_in.col);
    assign r_ext = CMP_W'(tok_in.row);
    assign m_ext = CMP_W'(margin);

    // nonzero depth, strictly inside the box after every edge is pulled in by the margin
    assign pix_hit = (tok_in.depth != '0)
                  && (CMP_W'(left_reg) + m_ext < c_ext)
                  && (CMP_W'(top_reg) + m_ext < r_ext)
                  && (CMP_W'(right_reg) > c_ext + m_ext)
                  && (CMP_W'(bottom_reg) > r_ext + m_ext);

    always_comb
    begin
        sum_base = tok_in.first ? '0 : sum_reg;
        cnt_base = tok_in.first ? COUNT_START : cnt_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (shift_en)
        begin
            sum_next = sum_in;
            cnt_next = cnt_in;
        end
        else if (tok_in.valid && tok_in.pix)
        begin
            sum_next = pix_hit ? sum_base + SUM_W'(tok_in.depth) : sum_base;
            cnt_next = pix_hit ? cnt_base + CNT_W'(1) : cnt_base;
        end
    end

    // bounds carry no reset: undefined until loaded
    always_ff @(posedge clk)
    begin
        if (tok_in.valid && !tok_in.pix && slot_hit)
        begin
            left_reg   <= tok_in.left;
            top_reg    <= tok_in.top;
            right_reg  <= tok_in.right;
            bottom_reg <= tok_in.bottom;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= COUNT_START;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_in;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

    assign sum_out = sum_reg;
    assign cnt_out = cnt_reg;

endmodule

### rtl/bmda_divider.sv
// restoring divider, one quotient bit a cycle, for the per-box mean
// depends on bmda_pkg
`timescale 1ns / 1ps

module bmda_divider
    import bmda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_W-1:0]      dividend,
    input  logic [CNT_W-1:0]      divisor,
    input  logic                  take,
    output logic                  done,
    output logic [DEPTH_BITS-1:0] quotient
);

    typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_DONE} dv_state_t;

    dv_state_t             state_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SUM_W-1:0]      rem_reg, dsr_reg;
    logic [DEPTH_BITS-1:0] quo_reg;
    logic                  fits;

    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= DV_RUN;
                        step_reg  <= STEP_W'(DEPTH_BITS - 1);
                    end
                end
                DV_RUN:
                begin
                    if (step_reg == '0)
                        state_reg <= DV_DONE;
                    else
                        step_reg <= step_reg - STEP_W'(1);
                end
                DV_DONE:
                begin
                    if (take)
                        state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    // datapath: divisor starts aligned to the top quotient bit
    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            rem_reg <= dividend;
            dsr_reg <= SUM_W'(divisor) << (DEPTH_BITS - 1);
            quo_reg <= '0;
        end
        else if (state_reg == DV_RUN)
        begin
            if (fits)
                rem_reg <= rem_reg - dsr_reg;
            quo_reg <= {quo_reg[DEPTH_BITS-2:0], fits};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign done     = (state_reg == DV_DONE);
    assign quotient = quo_reg;

endmodule

### rtl/box_mean_depth_accumulator.sv
// top level of the box mean depth accumulator: raster counter, row of box
// cells, report sequencer, divider and output register
// depends on bmda_pkg, bmda_in_if, bmda_out_if, bmda_cell, bmda_divider
`timescale 1ns / 1ps

//  channel      dir  payload                                          accepted when
//  items_in     in   action box_slot left/top/right/bottom_edge       valid & ready
//                    depth_sample
//  results_out  out  box_number mean_depth last_box                   valid & ready
//  cfg          in   cfg_index cfg_data                               cfg_wr_en
//
//  loads and pixels are taken one per cycle while the block is ready; each
//  walks the row of cells, one cell per cycle, registered in every cell on
//  the way; on the last pixel of a frame input stalls while that pixel leaves
//  the row, then while each reported box is divided by the bit-serial divider
//  and its mean loaded; with no boxes in use only the row drain remains
//  a full output register lets the last result of a frame wait while pixels
//  of the next frame flow in; a stalled result holds back the next divide
//  reset is asynchronous, no clearing pass: sums and counts reset in the cells

module box_mean_depth_accumulator
    import bmda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bmda_in_if.sink              items_in,
    bmda_out_if.source           results_out,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_START, ST_WAIT} state_t;

    // configuration registers
    logic [CFG_DIM_W-1:0]  frame_width_reg, frame_height_reg;
    logic [USED_CFG_W-1:0] boxes_in_use_reg;
    logic [MARGIN_W-1:0]   edge_margin_reg;

    // raster position
    logic [POS_W-1:0] col_reg, row_reg;
    logic [DIM_W-1:0] width_eff, height_eff, col_p1, row_p1;
    logic             row_end, frame_end, accept;

    // sequencer
    state_t           state_reg;
    logic [IDX_W-1:0] box_reg;
    logic [USE_W-1:0] used;
    logic             last_of_frame;

    // cell row
    bmda_token_t      tok [MAX_BOXES+1];
    logic [SUM_W-1:0] sums [MAX_BOXES+1];
    logic [CNT_W-1:0] cnts [MAX_BOXES+1];
    logic             shift_en;

    // divider and output register
    logic                  div_start, div_take, div_done;
    logic [DEPTH_BITS-1:0] div_quo;
    logic                  out_valid_reg, out_last_reg, out_load;
    logic [SLOT_W-1:0]     out_box_reg;
    logic [DEPTH_BITS-1:0] out_mean_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            boxes_in_use_reg <= RST_BOXES_IN_USE;
            edge_margin_reg  <= RST_EDGE_MARGIN;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_BOXES_IN_USE: boxes_in_use_reg <= cfg_data[USED_CFG_W-1:0];
                REG_EDGE_MARGIN:  edge_margin_reg  <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- raster counter ----------------
    assign items_in.ready = (state_reg == ST_RUN);
    assign accept         = items_in.valid && items_in.ready;

    assign width_eff  = clamp_dim(frame_width_reg);
    assign height_eff = clamp_dim(frame_height_reg);
    assign col_p1     = DIM_W'(col_reg) + DIM_W'(1);
    assign row_p1     = DIM_W'(row_reg) + DIM_W'(1);
    // a shrunk frame size ends the row or frame at once
    assign row_end    = (col_p1 >= width_eff);
    assign frame_end  = row_end && (row_p1 >= height_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept && items_in.action == ACT_PIXEL)
        begin
            col_reg <= row_end ? '0 : col_p1[POS_W-1:0];
            if (frame_end)
                row_reg <= '0;
            else if (row_end)
                row_reg <= row_p1[POS_W-1:0];
        end
    end

    // request entering cell 0
    always_comb
    begin
        tok[0].valid  = accept;
        tok[0].pix    = (items_in.action == ACT_PIXEL);
        tok[0].slot   = items_in.box_slot;
        tok[0].left   = items_in.left_edge;
        tok[0].top    = items_in.top_edge;
        tok[0].right  = items_in.right_edge;
        tok[0].bottom = items_in.bottom_edge;
        tok[0].depth  = items_in.depth_sample;
        tok[0].col    = col_reg;
        tok[0].row    = row_reg;
        // first pixel of a frame clears the accumulators
        tok[0].first  = (col_reg == '0) && (row_reg == '0);
        // only a pixel can end a frame
        tok[0].last   = (items_in.action == ACT_PIXEL) && frame_end;
    end

    // ---------------- row of box cells ----------------
    // past the last cell the report shift brings in a cleared box
    assign sums[MAX_BOXES] = '0;
    assign cnts[MAX_BOXES] = COUNT_START;

    for (genvar k = 0; k < MAX_BOXES; k++)
    begin : g_cell
        bmda_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(k)),
            .margin   (edge_margin_reg),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .shift_en (shift_en),
            .sum_in   (sums[k+1]),
            .cnt_in   (cnts[k+1]),
            .sum_out  (sums[k]),
            .cnt_out  (cnts[k])
        );
    end

    // ---------------- report sequencer ----------------
    assign used = (32'(boxes_in_use_reg) > 32'(MAX_BOXES)) ? USE_W'(MAX_BOXES)
                                                           : USE_W'(boxes_in_use_reg);
    assign last_of_frame = (32'(box_reg) + 32'd1 == 32'(used));

    // the divider takes the box being reported from cell 0; the row shifts toward it as the divide starts
    assign div_start = (state_reg == ST_START);
    assign shift_en  = (state_reg == ST_START);
    assign out_load  = (state_reg == ST_WAIT) && div_done
                    && (!out_valid_reg || results_out.ready);
    assign div_take  = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            box_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (accept && items_in.action == ACT_PIXEL && frame_end)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    // frame-end pixel has passed every cell
                    if (tok[MAX_BOXES].valid && tok[MAX_BOXES].last)
                    begin
                        box_reg   <= '0;
                        state_reg <= (used == '0) ? ST_RUN : ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (out_load)
                    begin
                        if (last_of_frame)
                            state_reg <= ST_RUN;
                        else
                        begin
                            box_reg   <= box_reg + IDX_W'(1);
                            state_reg <= ST_START;
                        end
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    bmda_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sums[0]),
        .divisor  (cnts[0]),
        .take     (div_take),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (results_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_box_reg  <= SLOT_W'(box_reg);
            out_mean_reg <= div_quo;
            out_last_reg <= last_of_frame;
        end
    end

    assign results_out.valid      = out_valid_reg;
    assign results_out.box_number = out_box_reg;
    assign results_out.mean_depth = out_mean_reg;
    assign results_out.last_box   = out_last_reg;

endmodule

### tb/bmda_mean_checker.sv
// predictor and result check for the box mean depth accumulator
// depends on bmda_pkg, bmda_in_if and bmda_out_if; watches the dut channels and configuration port only
`timescale 1ns / 1ps

module bmda_mean_checker
    import bmda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bmda_in_if                   requests,
    bmda_out_if                  means,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   error_count,
    output int                   means_due
);

    typedef struct packed {
        logic [SLOT_W-1:0]     box;
        logic [DEPTH_BITS-1:0] mean;
        logic                  last;
    } box_mean_t;

    box_mean_t mean_queue [$];

    // box corners as loaded
    logic [EDGE_W-1:0] lo_col [MAX_BOXES];
    logic [EDGE_W-1:0] lo_row [MAX_BOXES];
    logic [EDGE_W-1:0] hi_col [MAX_BOXES];
    logic [EDGE_W-1:0] hi_row [MAX_BOXES];

    logic [SUM_W-1:0] acc_sum [MAX_BOXES];
    logic [CNT_W-1:0] acc_cnt [MAX_BOXES];
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;

    logic [CFG_DIM_W-1:0]  width_reg;
    logic [CFG_DIM_W-1:0]  height_reg;
    logic [USED_CFG_W-1:0] used_reg;
    logic [MARGIN_W-1:0]   margin_reg;

    // zero acts as one, oversize acts as the largest frame
    function automatic int frame_span(input logic [CFG_DIM_W-1:0] v);
        if (v == '0)
            return 1;
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    task automatic clear_sums();
        for (int k = 0; k < MAX_BOXES; k++)
        begin
            acc_sum[k] = '0;
            acc_cnt[k] = COUNT_START;
        end
    endtask

    task automatic predict_request();
        int        w;
        int        h;
        int        m;
        int        c;
        int        r;
        int        n;
        box_mean_t e;
        logic [SUM_W-1:0] quotient;
        if (requests.action == ACT_LOAD)
        begin
            if (int'(requests.box_slot) < MAX_BOXES)
            begin
                lo_col[requests.box_slot] = requests.left_edge;
                lo_row[requests.box_slot] = requests.top_edge;
                hi_col[requests.box_slot] = requests.right_edge;
                hi_row[requests.box_slot] = requests.bottom_edge;
            end
            return;
        end
        w = frame_span(width_reg);
        h = frame_span(height_reg);
        m = int'(margin_reg);
        c = int'(col_pos);
        r = int'(row_pos);
        if (c == 0 && r == 0)
            clear_sums();
        if (requests.depth_sample != '0)
        begin
            for (int k = 0; k < MAX_BOXES; k++)
            begin
                if (int'(lo_col[k]) + m < c && int'(lo_row[k]) + m < r &&
                    int'(hi_col[k]) > c + m && int'(hi_row[k]) > r + m)
                begin
                    acc_sum[k] = acc_sum[k] + SUM_W'(requests.depth_sample);
                    acc_cnt[k] = acc_cnt[k] + CNT_W'(1);
                end
            end
        end
        if (c + 1 < w)
        begin
            col_pos = POS_W'(c + 1);
            return;
        end
        col_pos = '0;
        if (r + 1 < h)
        begin
            row_pos = POS_W'(r + 1);
            return;
        end
        row_pos = '0;
        n = (int'(used_reg) > MAX_BOXES) ? MAX_BOXES : int'(used_reg);
        for (int k = 0; k < n; k++)
        begin
            quotient = acc_sum[k] / SUM_W'(acc_cnt[k]);
            e.box    = SLOT_W'(k);
            e.mean   = quotient[DEPTH_BITS-1:0];
            e.last   = (k == n - 1);
            mean_queue = {mean_queue, e};
        end
    endtask

    task automatic check_mean();
        box_mean_t e;
        if (mean_queue.size() == 0)
        begin
            $error("unexpected mean: box_number %0d mean_depth %0d last_box %0d",
                   means.box_number, means.mean_depth, means.last_box);
            error_count++;
            return;
        end
        e = mean_queue.pop_front();
        if (means.box_number !== e.box)
        begin
            $error("box_number expected %0d actual %0d", e.box, means.box_number);
            error_count++;
        end
        if (means.mean_depth !== e.mean)
        begin
            $error("mean_depth expected %0d actual %0d", e.mean, means.mean_depth);
            error_count++;
        end
        if (means.last_box !== e.last)
        begin
            $error("last_box expected %0d actual %0d", e.last, means.last_box);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_BOXES; k++)
            begin
                lo_col[k] = '0;
                lo_row[k] = '0;
                hi_col[k] = '0;
                hi_row[k] = '0;
            end
            clear_sums();
            col_pos     = '0;
            row_pos     = '0;
            width_reg   = RST_FRAME_WIDTH;
            height_reg  = RST_FRAME_HEIGHT;
            used_reg    = RST_BOXES_IN_USE;
            margin_reg  = RST_EDGE_MARGIN;
            mean_queue.delete();
            error_count = 0;
            means_due   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  = cfg_data[CFG_DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = cfg_data[CFG_DIM_W-1:0];
                    REG_BOXES_IN_USE: used_reg   = cfg_data[USED_CFG_W-1:0];
                    REG_EDGE_MARGIN:  margin_reg = cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end
            if (requests.valid && requests.ready)
                predict_request();
            if (means.valid && means.ready)
                check_mean();
            means_due = mean_queue.size();
        end
    end

endmodule

### tb/tb_top.sv
// top of the box mean depth accumulator testbench: clock, reset, stimulus
// and verdict; depends on bmda_pkg, both channel interfaces, the dut and
// bmda_mean_checker
`timescale 1ns / 1ps

module tb_top;
    import bmda_pkg::*;

    // generous ceiling on the whole run, in ns
    localparam int LIMIT_NS      = 5_000_000;
    // cycles to let the cell row and divider empty before touching registers
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 180;
    // pixels sent into the oversize frames, far short of a full frame
    localparam int PARTIAL_PIXELS = 48;

    // depths of the directed 3x3 frame, center and most corners at the extremes
    localparam logic [DEPTH_BITS-1:0] CORNER_DEPTHS [9] = '{
        16'hFFFF, 16'h0001, 16'h0000,
        16'h1234, 16'hFFFF, 16'h0000,
        16'h8000, 16'h0001, 16'hFFFF
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int means_due;
    // chance in percent of a gap before a request or a stall of the result side
    int idle_pct;
    int random_sent;

    bmda_in_if  requests ();
    bmda_out_if means ();

    box_mean_depth_accumulator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .items_in    (requests),
        .results_out (means),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    bmda_mean_checker u_mean_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .requests    (requests),
        .means       (means),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (fail_count),
        .means_due   (means_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the dut hangs
    initial
    begin
        #(LIMIT_NS);
        $display("tb_top: errors");
        $finish;
    end

    // result side: random stall bursts, none when idle_pct is zero
    initial
    begin
        means.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
            begin
                means.ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
                means.ready <= 1'b1;
        end
    end

    // zero, one and all ones half the time, random depths otherwise; zero often enough to hit the invalid case
    function automatic logic [DEPTH_BITS-1:0] rand_depth();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            3:       return DEPTH_BITS'(1);
            default: return DEPTH_BITS'($urandom);
        endcase
    endfunction

    // edges near the small frames most of the time, anywhere now and then
    function automatic logic [EDGE_W-1:0] rand_edge();
        if ($urandom_range(0, 7) == 0)
            return EDGE_W'($urandom);
        return EDGE_W'($urandom_range(0, 9));
    endfunction

    // one request, with an optional gap ahead of it; returns once accepted
    task automatic send_request(
        input logic                  act,
        input logic [SLOT_W-1:0]     slot,
        input logic [EDGE_W-1:0]     l,
        input logic [EDGE_W-1:0]     t,
        input logic [EDGE_W-1:0]     r,
        input logic [EDGE_W-1:0]     b,
        input logic [DEPTH_BITS-1:0] d
    );
        int gap;
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            requests.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        requests.valid        <= 1'b1;
        requests.action       <= act;
        requests.box_slot     <= slot;
        requests.left_edge    <= l;
        requests.top_edge     <= t;
        requests.right_edge   <= r;
        requests.bottom_edge  <= b;
        requests.depth_sample <= d;
        @(posedge clk);
        while (!requests.ready)
            @(posedge clk);
    endtask

    // load request; the depth field is don't-care and gets noise
    task automatic send_load(
        input logic [SLOT_W-1:0] slot,
        input logic [EDGE_W-1:0] l,
        input logic [EDGE_W-1:0] t,
        input logic [EDGE_W-1:0] r,
        input logic [EDGE_W-1:0] b
    );
        send_request(ACT_LOAD, slot, l, t, r, b, DEPTH_BITS'($urandom));
    endtask

    // pixel request; the box fields are don't-care and get noise
    task automatic send_pixel(input logic [DEPTH_BITS-1:0] d);
        send_request(ACT_PIXEL, SLOT_W'($urandom), EDGE_W'($urandom), EDGE_W'($urandom),
                     EDGE_W'($urandom), EDGE_W'($urandom), d);
    endtask

    // stop sending, wait for every expected mean, then let the cell row empty
    task automatic drain();
        @(negedge clk);
        requests.valid <= 1'b0;
        while (means_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // rewrite all four registers with the block idle; the narrow registers
    // get noise in the unused high bits of the data bus
    task automatic set_config(
        input logic [CFG_DIM_W-1:0]  w,
        input logic [CFG_DIM_W-1:0]  h,
        input logic [USED_CFG_W-1:0] used,
        input logic [MARGIN_W-1:0]   margin
    );
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= REG_BOXES_IN_USE;
        cfg_data  <= {(CFG_W - USED_CFG_W)'($urandom), used};
        @(negedge clk);
        cfg_index <= REG_EDGE_MARGIN;
        cfg_data  <= {(CFG_W - MARGIN_W)'($urandom), margin};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DIM_W-1:0]  w;
        logic [CFG_DIM_W-1:0]  h;
        logic [USED_CFG_W-1:0] used;
        logic [MARGIN_W-1:0]   margin;
        int                    wd;
        int                    hd;
        int                    n;

        // every input known from time zero
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = REG_FRAME_WIDTH;
        cfg_data              = '0;
        requests.valid        = 1'b0;
        requests.action       = ACT_LOAD;
        requests.box_slot     = '0;
        requests.left_edge    = '0;
        requests.top_edge     = '0;
        requests.right_edge   = '0;
        requests.bottom_edge  = '0;
        requests.depth_sample = '0;
        idle_pct              = 0;
        random_sent           = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: 3x3 frame, all sixteen boxes reported, no trim
        set_config(CFG_DIM_W'(3), CFG_DIM_W'(3), USED_CFG_W'(16), MARGIN_W'(0));
        // every slot loaded before the first pixel so no bounds are read unwritten
        send_load(SLOT_W'(0), '0, '0, '1, '1);   // whole frame, interior hits
        send_load(SLOT_W'(1), '1, '1, '0, '0);   // inverted, never hits
        send_load(SLOT_W'(2), '0, '0, EDGE_W'(2), EDGE_W'(2));   // center pixel only
        for (int k = 3; k < MAX_BOXES; k++)
            send_load(SLOT_W'(k), rand_edge(), rand_edge(), rand_edge(), rand_edge());
        for (int k = 0; k < 9; k++)
            send_pixel(CORNER_DEPTHS[k]);

        // width above the maximum, boxes in use above range; only the start
        // of the first row is scanned
        idle_pct = 5;
        set_config(13'h1FFF, CFG_DIM_W'(2), USED_CFG_W'(31), MARGIN_W'(0));
        for (int k = 0; k < MAX_BOXES; k++)
            send_load(SLOT_W'(k), EDGE_W'($urandom), '0, EDGE_W'($urandom),
                      EDGE_W'($urandom_range(2, 4095)));
        for (int k = 0; k < PARTIAL_PIXELS; k++)
            send_pixel(rand_depth());

        // width shrinks under the running column, tallest frame, largest trim
        set_config(CFG_DIM_W'(1), CFG_DIM_W'(MAX_DIM), USED_CFG_W'(16), '1);
        for (int k = 0; k < PARTIAL_PIXELS; k++)
            send_pixel(rand_depth());

        // zero sizes act as a 1x1 frame, so every pixel ends a frame
        set_config('0, '0, USED_CFG_W'(1), MARGIN_W'(0));
        for (int k = 0; k < 4; k++)
            send_pixel(rand_depth());

        // random phases of small frames; a phase may stop mid-frame so the
        // next setting lands on a partly scanned frame, shrink included
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 8;
                default: idle_pct = 25;
            endcase
            w  = ($urandom_range(0, 9) == 0) ? '0 : CFG_DIM_W'($urandom_range(1, 7));
            h  = ($urandom_range(0, 9) == 0) ? '0 : CFG_DIM_W'($urandom_range(1, 5));
            wd = (w == '0) ? 1 : int'(w);
            hd = (h == '0) ? 1 : int'(h);
            case ($urandom_range(0, 7))
                0:       used = '0;
                1:       used = USED_CFG_W'($urandom_range(17, 31));
                default: used = USED_CFG_W'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 5) == 0)
                margin = MARGIN_W'($urandom_range(3, 255));
            else
                margin = MARGIN_W'($urandom_range(0, 2));
            set_config(w, h, used, margin);
            n = $urandom_range(1, 3) * wd * hd;
            if ($urandom_range(0, 2) == 0)
                n += $urandom_range(1, wd * hd);
            for (int k = 0; k < n; k++)
            begin
                // occasional reload while the frame is running
                if ($urandom_range(0, 9) == 0)
                begin
                    send_load(SLOT_W'($urandom), rand_edge(), rand_edge(), rand_edge(),
                              rand_edge());
                    random_sent++;
                end
                send_pixel(rand_depth());
                random_sent++;
            end
        end

        // closing stretch with no gaps and no stalls on either side
        idle_pct = 0;
        set_config(CFG_DIM_W'(4), CFG_DIM_W'(3), USED_CFG_W'(16), MARGIN_W'(1));
        for (int k = 0; k < 36; k++)
        begin
            if (k == 17)
                send_load(SLOT_W'($urandom), '0, '0, EDGE_W'(5), EDGE_W'(4));
            send_pixel(rand_depth());
        end

        drain();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
